@@ sv/hsv2rgb_pkg.sv @@
// Package: transaction types and fixed-point constants for the HSV to RGB converter.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  typedef struct packed {
    logic [13:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
    logic [7:0]  alpha_in;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha_out;
    logic       hue_error;
  } out_t;

  // One 60-degree sector in 1/32 degree units, and the 360-degree limit.
  localparam logic [13:0] SECTOR_UNITS = 14'd1920;
  localparam logic [13:0] HUE_LIMIT    = 14'd11520;
  localparam logic [10:0] SECTOR_K     = 11'd1920;

  // Full-scale denominator 255 * 1920 = 2^7 * 3825, and its half for rounding.
  localparam logic [18:0] FULL_DEN  = 19'd489600;
  localparam logic [26:0] HALF_DEN  = 27'd244800;
  localparam int          DEN_SHIFT = 7;
  localparam logic [19:0] DEN_ODD   = 20'd3825;

  // floor(2^32 / 3825); the estimate is low by at most one.
  localparam logic [20:0] RECIP_M     = 21'd1122867;
  localparam int          RECIP_SHIFT = 32;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_t;

endpackage

@@ sv/hsv2rgb_lane.sv @@
// Channel lane: round(v * (489600 - s*k) / 489600) over four register stages.
`timescale 1ns / 1ps

module hsv2rgb_lane (
  input  logic        clk,
  input  logic [7:0]  sat,
  input  logic [7:0]  val,
  input  logic [10:0] k,
  output logic [7:0]  q
);

  logic [18:0] t_nxt, t_r;
  logic [7:0]  v_r;
  logic [26:0] n;
  logic [19:0] y_nxt, y_r;
  logic [40:0] prod_nxt, prod_r;
  logic [19:0] y_d_r;
  logic [7:0]  q0;
  logic [19:0] rem;
  logic [8:0]  q_sum;
  logic [7:0]  q_nxt, q_r;

  always_comb begin
    t_nxt = hsv2rgb_pkg::FULL_DEN - (19'(sat) * 19'(k));
  end

  // Stage B: numerator with rounding offset; the 2^7 factor of the divisor drops out here.
  always_comb begin
    n     = 27'(v_r) * 27'(t_r) + hsv2rgb_pkg::HALF_DEN;
    y_nxt = n[26:hsv2rgb_pkg::DEN_SHIFT];
  end

  always_comb begin
    prod_nxt = 41'(y_r) * 41'(hsv2rgb_pkg::RECIP_M);
  end

  // Stage D: reciprocal estimate plus one correction step.
  always_comb begin
    q0    = prod_r[hsv2rgb_pkg::RECIP_SHIFT +: 8];
    rem   = y_d_r - 20'(q0) * hsv2rgb_pkg::DEN_ODD;
    q_sum = 9'(q0) + 9'(rem >= hsv2rgb_pkg::DEN_ODD);
    q_nxt = q_sum[8] ? 8'hFF : q_sum[7:0];
  end

  always_ff @(posedge clk) begin
    t_r    <= t_nxt;
    v_r    <= val;
    y_r    <= y_nxt;
    prod_r <= prod_nxt;
    y_d_r  <= y_r;
    q_r    <= q_nxt;
  end

  assign q = q_r;

endmodule

@@ sv/hsv_to_rgb_converter.sv @@
// Top level: pipelined HSV plus alpha to RGBA converter.
// Pipeline: sector split, four lane stages of multiply and constant divide, channel select;
// each stage ends in a register.
// Throughput: one transaction per cycle; busy is always low.
// Reset: synchronous, active low; clears the valid bits so no stale result appears.
`timescale 1ns / 1ps

module hsv_to_rgb_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  hsv2rgb_pkg::in_t   in_data,
  output logic               out_valid,
  output hsv2rgb_pkg::out_t  out_data
);

  localparam int LANE_STAGES = 4;

  typedef struct packed {
    logic                 valid;
    logic                 zero_sat;
    logic                 illegal;
    hsv2rgb_pkg::sector_t sector;
    logic [7:0]           val;
    logic [7:0]           alpha;
  } side_t;

  logic        accept;
  logic [2:0]  sec_cnt;
  logic [13:0] hue_base;
  logic [10:0] frac;
  logic [10:0] kmid_nxt, kmid_r;
  logic [7:0]  sat_r;
  side_t       s1_nxt, s1_r;
  side_t       side_r [LANE_STAGES];
  side_t       s5;
  logic [7:0]  q_mid, q_lo, q_hi;
  hsv2rgb_pkg::out_t out_nxt, out_r;
  logic        out_valid_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Stage 1: sector by compare against the sector boundaries, then the fraction.
  always_comb begin
    sec_cnt = 3'd0;
    for (int i = 1; i < 6; i++) begin
      if (in_data.hue >= 14'(i) * hsv2rgb_pkg::SECTOR_UNITS) begin
        sec_cnt = 3'(i);
      end
    end
    hue_base = 14'(sec_cnt) * hsv2rgb_pkg::SECTOR_UNITS;
    frac     = 11'(in_data.hue - hue_base);
    kmid_nxt = sec_cnt[0] ? frac : (hsv2rgb_pkg::SECTOR_K - frac);

    s1_nxt.valid    = accept;
    s1_nxt.zero_sat = (in_data.saturation == 8'd0);
    s1_nxt.illegal  = (in_data.hue >= hsv2rgb_pkg::HUE_LIMIT);
    s1_nxt.sector   = hsv2rgb_pkg::sector_t'(sec_cnt);
    s1_nxt.val      = in_data.brightness;
    s1_nxt.alpha    = in_data.alpha_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else begin
      s1_r.valid <= s1_nxt.valid;
    end
    s1_r.zero_sat <= s1_nxt.zero_sat;
    s1_r.illegal  <= s1_nxt.illegal;
    s1_r.sector   <= s1_nxt.sector;
    s1_r.val      <= s1_nxt.val;
    s1_r.alpha    <= s1_nxt.alpha;
    kmid_r        <= kmid_nxt;
    sat_r         <= in_data.saturation;
  end

  hsv2rgb_lane u_lane_mid (
    .clk (clk),
    .sat (sat_r),
    .val (s1_r.val),
    .k   (kmid_r),
    .q   (q_mid)
  );

  hsv2rgb_lane u_lane_lo (
    .clk (clk),
    .sat (sat_r),
    .val (s1_r.val),
    .k   (hsv2rgb_pkg::SECTOR_K),
    .q   (q_lo)
  );

  // Side info rides alongside the lanes.
  always_ff @(posedge clk) begin
    for (int i = 0; i < LANE_STAGES; i++) begin
      if (!rst_n) begin
        side_r[i].valid <= 1'b0;
      end else begin
        side_r[i].valid <= (i == 0) ? s1_r.valid : side_r[(i == 0) ? 0 : i - 1].valid;
      end
      side_r[i].zero_sat <= (i == 0) ? s1_r.zero_sat : side_r[(i == 0) ? 0 : i - 1].zero_sat;
      side_r[i].illegal  <= (i == 0) ? s1_r.illegal  : side_r[(i == 0) ? 0 : i - 1].illegal;
      side_r[i].sector   <= (i == 0) ? s1_r.sector   : side_r[(i == 0) ? 0 : i - 1].sector;
      side_r[i].val      <= (i == 0) ? s1_r.val      : side_r[(i == 0) ? 0 : i - 1].val;
      side_r[i].alpha    <= (i == 0) ? s1_r.alpha    : side_r[(i == 0) ? 0 : i - 1].alpha;
    end
  end

  assign s5   = side_r[LANE_STAGES - 1];
  assign q_hi = s5.val;

  // Stage 6: place chroma, secondary and floor per sector; gray and bad hue override.
  always_comb begin
    out_nxt.alpha_out = s5.alpha;
    out_nxt.hue_error = 1'b0;
    unique case (s5.sector)
      hsv2rgb_pkg::SEC_RED_YELLOW: begin
        out_nxt.red = q_hi;  out_nxt.green = q_mid; out_nxt.blue = q_lo;
      end
      hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
        out_nxt.red = q_mid; out_nxt.green = q_hi;  out_nxt.blue = q_lo;
      end
      hsv2rgb_pkg::SEC_GREEN_CYAN: begin
        out_nxt.red = q_lo;  out_nxt.green = q_hi;  out_nxt.blue = q_mid;
      end
      hsv2rgb_pkg::SEC_CYAN_BLUE: begin
        out_nxt.red = q_lo;  out_nxt.green = q_mid; out_nxt.blue = q_hi;
      end
      hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
        out_nxt.red = q_mid; out_nxt.green = q_lo;  out_nxt.blue = q_hi;
      end
      default: begin
        out_nxt.red = q_hi;  out_nxt.green = q_lo;  out_nxt.blue = q_mid;
      end
    endcase
    if (s5.zero_sat) begin
      out_nxt.red   = s5.val;
      out_nxt.green = s5.val;
      out_nxt.blue  = s5.val;
    end else if (s5.illegal) begin
      out_nxt.red       = 8'd0;
      out_nxt.green     = 8'd0;
      out_nxt.blue      = 8'd0;
      out_nxt.alpha_out = 8'd0;
      out_nxt.hue_error = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s5.valid;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ sv/hsv2rgb_checker.sv @@
// Checker: port-level assertions for the HSV to RGB converter, bound to the top level.
`timescale 1ns / 1ps

module hsv2rgb_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input hsv2rgb_pkg::in_t  in_data,
  input logic              out_valid,
  input hsv2rgb_pkg::out_t out_data
);

  localparam int LATENCY = 6;

  // Every accepted transaction yields a result strobe.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result strobe missing after accepted transaction");

  // No strobe without a matching accepted transaction.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a transaction");

  // An illegal hue with color must come out flagged.
  a_err_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.hue >= hsv2rgb_pkg::HUE_LIMIT && in_data.saturation != 8'd0)
      |-> ##LATENCY (out_valid && out_data.hue_error))
    else $error("illegal hue not flagged");

  // Gray input passes through unflagged.
  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.saturation == 8'd0)
      |-> ##LATENCY (out_valid && !out_data.hue_error &&
                     out_data.red == $past(in_data.brightness, LATENCY) &&
                     out_data.green == out_data.red && out_data.blue == out_data.red))
    else $error("gray input not passed through");

  // A flagged result carries all-zero RGBA.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.hue_error) |->
      (out_data.red == 8'd0 && out_data.green == 8'd0 &&
       out_data.blue == 8'd0 && out_data.alpha_out == 8'd0))
    else $error("flagged result not zero");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (.*);

@@ bench/tb_hsv_to_rgb_converter.sv @@
// Testbench: HSV plus alpha to RGBA converter, self-checking against a built-in predictor.
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter;

  localparam int RANDOM_ITEMS = 1250;
  localparam int NO_GAP_TAIL  = 200;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 12;

  // Expected RGBA queue plus the color math that fills it.
  class rgba_scoreboard;
    hsv2rgb_pkg::out_t expected_rgba[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned gray_hits;
    int unsigned bad_hue_hits;
    int unsigned sector_hits[6];

    function new();
      errors = 0;
      checked = 0;
      gray_hits = 0;
      bad_hue_hits = 0;
      foreach (sector_hits[i]) sector_hits[i] = 0;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    function int unsigned pending();
      return expected_rgba.size();
    endfunction

    // v - v*s*k / (255*1920), rounded to nearest with ties up, clamped at 255
    function logic [7:0] scale_channel(int unsigned v, int unsigned s, int unsigned k);
      int unsigned num;
      int unsigned q;
      num = v * 32'(hsv2rgb_pkg::FULL_DEN) - v * s * k;
      q = (num + 32'(hsv2rgb_pkg::HALF_DEN)) / 32'(hsv2rgb_pkg::FULL_DEN);
      return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function hsv2rgb_pkg::out_t predict_rgba(hsv2rgb_pkg::in_t px);
      hsv2rgb_pkg::out_t    o;
      hsv2rgb_pkg::sector_t sec;
      int unsigned          frac;
      int unsigned          kmid;
      int unsigned          v;
      int unsigned          s;
      logic [7:0]           hi;
      logic [7:0]           lo;
      logic [7:0]           mid;
      o = '0;
      if (px.saturation == 8'd0) begin
        o.red = px.brightness;
        o.green = px.brightness;
        o.blue = px.brightness;
        o.alpha_out = px.alpha_in;
        gray_hits++;
        return o;
      end
      if (px.hue >= hsv2rgb_pkg::HUE_LIMIT) begin
        o.hue_error = 1'b1;
        bad_hue_hits++;
        return o;
      end
      sec  = hsv2rgb_pkg::sector_t'(3'(px.hue / hsv2rgb_pkg::SECTOR_UNITS));
      frac = 32'(px.hue % hsv2rgb_pkg::SECTOR_UNITS);
      kmid = sec[0] ? frac : (32'(hsv2rgb_pkg::SECTOR_UNITS) - frac);
      v    = 32'(px.brightness);
      s    = 32'(px.saturation);
      hi   = scale_channel(v, s, 0);
      lo   = scale_channel(v, s, 32'(hsv2rgb_pkg::SECTOR_UNITS));
      mid  = scale_channel(v, s, kmid);
      sector_hits[sec]++;
      case (sec)
        hsv2rgb_pkg::SEC_RED_YELLOW:   begin o.red = hi;  o.green = mid; o.blue = lo;  end
        hsv2rgb_pkg::SEC_YELLOW_GREEN: begin o.red = mid; o.green = hi;  o.blue = lo;  end
        hsv2rgb_pkg::SEC_GREEN_CYAN:   begin o.red = lo;  o.green = hi;  o.blue = mid; end
        hsv2rgb_pkg::SEC_CYAN_BLUE:    begin o.red = lo;  o.green = mid; o.blue = hi;  end
        hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin o.red = mid; o.green = lo;  o.blue = hi;  end
        default:                       begin o.red = hi;  o.green = lo;  o.blue = mid; end
      endcase
      o.alpha_out = px.alpha_in;
      return o;
    endfunction

    function void note_pixel(hsv2rgb_pkg::in_t px);
      expected_rgba.push_back(predict_rgba(px));
    endfunction

    task check_pixel(hsv2rgb_pkg::out_t got);
      hsv2rgb_pkg::out_t want;
      if (expected_rgba.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = expected_rgba.pop_front();
      checked++;
      if (got.red !== want.red)
        report($sformatf("red got %0d want %0d", got.red, want.red));
      if (got.green !== want.green)
        report($sformatf("green got %0d want %0d", got.green, want.green));
      if (got.blue !== want.blue)
        report($sformatf("blue got %0d want %0d", got.blue, want.blue));
      if (got.alpha_out !== want.alpha_out)
        report($sformatf("alpha got %0d want %0d", got.alpha_out, want.alpha_out));
      if (got.hue_error !== want.hue_error)
        report($sformatf("hue_error got %b want %b", got.hue_error, want.hue_error));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  hsv2rgb_pkg::in_t  in_data = '0;
  logic busy;
  logic out_valid;
  hsv2rgb_pkg::out_t out_data;

  rgba_scoreboard sb = new();
  int unsigned    cycle_count = 0;

  hsv_to_rgb_converter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Monitor: sees pre-edge values, so acceptance and result capture are race-free.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (start && !busy) sb.note_pixel(in_data);
      if (out_valid) sb.check_pixel(out_data);
    end
  end

  always @(posedge clk) begin
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending", cycle_count,
               sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function hsv2rgb_pkg::in_t mk_pixel(int unsigned h, int unsigned s, int unsigned v,
                                      int unsigned a);
    hsv2rgb_pkg::in_t px;
    px.hue = h[13:0];
    px.saturation = s[7:0];
    px.brightness = v[7:0];
    px.alpha_in = a[7:0];
    return px;
  endfunction

  // Called right after a rising edge; returns at the edge that took the transaction.
  task drive_item(hsv2rgb_pkg::in_t px);
    bit took;
    start <= 1'b1;
    in_data <= px;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end
  endtask

  task idle_burst(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function hsv2rgb_pkg::in_t random_pixel();
    int unsigned h;
    int unsigned s;
    int unsigned v;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 65)
      h = $urandom_range(11519);
    else if (pick < 80)
      // land on or next to a sector edge
      h = $urandom_range(6) * 32'(hsv2rgb_pkg::SECTOR_UNITS) + $urandom_range(4) - 2;
    else if (pick < 90)
      h = $urandom_range(16383, 11520);
    else
      h = $urandom_range(16383);
    pick = $urandom_range(99);
    s = (pick < 10) ? 0 : (pick < 20) ? 255 : $urandom_range(255);
    pick = $urandom_range(99);
    v = (pick < 5) ? 0 : (pick < 10) ? 255 : $urandom_range(255);
    return mk_pixel(h, s, v, $urandom_range(255));
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every sector and its edges, gray and illegal hue.
    drive_item(mk_pixel(0, 255, 255, 255));
    drive_item(mk_pixel(1919, 255, 255, 0));
    drive_item(mk_pixel(1920, 255, 255, 128));
    drive_item(mk_pixel(3839, 200, 180, 1));
    drive_item(mk_pixel(3840, 255, 255, 254));
    drive_item(mk_pixel(5760, 128, 255, 77));
    drive_item(mk_pixel(7680, 255, 128, 170));
    drive_item(mk_pixel(9600, 1, 255, 85));
    drive_item(mk_pixel(11519, 255, 255, 255));
    drive_item(mk_pixel(960, 255, 255, 255));
    drive_item(mk_pixel(10560, 127, 201, 33));
    drive_item(mk_pixel(4000, 255, 0, 255));
    drive_item(mk_pixel(11520, 255, 255, 255));
    drive_item(mk_pixel(16383, 1, 0, 200));
    drive_item(mk_pixel(16383, 0, 255, 255));
    drive_item(mk_pixel(11520, 0, 99, 42));
    drive_item(mk_pixel(5000, 0, 0, 0));
    drive_item(mk_pixel(5000, 0, 255, 255));
    drive_item(mk_pixel(8191, 170, 85, 170));
    drive_item(mk_pixel(2047, 85, 170, 85));
    drive_item(mk_pixel(1, 255, 1, 255));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      drive_item(random_pixel());
      if (i < RANDOM_ITEMS - NO_GAP_TAIL && $urandom_range(99) < 30)
        idle_burst($urandom_range(8, 1));
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d RGBA transactions: %0d gray, %0d illegal hue.",
             sb.checked, sb.gray_hits, sb.bad_hue_hits);
    $display("Per-sector hits: %0d %0d %0d %0d %0d %0d", sb.sector_hits[0],
             sb.sector_hits[1], sb.sector_hits[2], sb.sector_hits[3],
             sb.sector_hits[4], sb.sector_hits[5]);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
